FILE: src/lfu_pkg.sv
// shared constants, types and helpers for the lfu page replacement unit
`timescale 1ns / 1ps

package lfu_pkg;

    localparam int FrameSlots = 16;
    localparam int SlotIdxW   = $clog2(FrameSlots);
    localparam int FramesW    = 5;
    localparam int PageW      = 16;
    localparam int CountW     = 16;
    localparam int StampW     = 32;
    localparam int TotalW     = 32;
    localparam int EntryW     = PageW + CountW + StampW;
    localparam int CfgAddrW   = 3;
    localparam int CfgDataW   = 32;

    localparam logic [CountW-1:0] CountMax  = {CountW{1'b1}};
    localparam logic [CountW-1:0] CountOne  = CountW'(1);
    localparam logic [TotalW-1:0] WordMax   = {TotalW{1'b1}};
    localparam logic [FramesW-1:0] FramesReset = FramesW'(FrameSlots);

    // register index, taken from paddr[2]
    localparam logic CfgIdxFrames = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic                hit;
        logic [SlotIdxW-1:0] hit_idx;
        logic [CountW-1:0]   hit_count;
        logic                empty;
        logic [SlotIdxW-1:0] empty_idx;
        logic [SlotIdxW-1:0] vict_idx;
        logic [PageW-1:0]    vict_page;
    } scan_res_t;

    function automatic logic [TotalW-1:0] sat_inc32(input logic [TotalW-1:0] v);
        return (v == WordMax) ? v : v + TotalW'(1);
    endfunction

endpackage

FILE: src/lfu_slot_ram.sv
// single-port-write, registered-read memory holding the frame slot entries
`timescale 1ns / 1ps

module lfu_slot_ram #(
    parameter int Depth = 16,
    parameter int Width = 64,
    parameter int AddrW = $clog2(Depth)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AddrW-1:0] waddr,
    input  logic [Width-1:0] wdata,
    input  logic             re,
    input  logic [AddrW-1:0] raddr,
    output logic [Width-1:0] rdata
);

    logic [Width-1:0] mem [Depth];
    logic [Width-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/lfu_victim_scan.sv
// walks the slot entries one per cycle: first hit, first empty slot and lfu victim
`timescale 1ns / 1ps

module lfu_victim_scan (
    input  logic                           aclk,
    input  logic                           start,
    input  logic [lfu_pkg::PageW-1:0]      ref_page,
    input  logic                           ent_strobe,
    input  logic [lfu_pkg::SlotIdxW-1:0]   ent_idx,
    input  logic                           ent_valid,
    input  logic [lfu_pkg::PageW-1:0]      ent_page,
    input  logic [lfu_pkg::CountW-1:0]     ent_count,
    input  logic [lfu_pkg::StampW-1:0]     ent_stamp,
    output lfu_pkg::scan_res_t             res
);

    lfu_pkg::scan_res_t                 res_reg, res_next;
    logic                               have_best_reg, have_best_next;
    logic [lfu_pkg::CountW-1:0]         best_count_reg, best_count_next;
    logic [lfu_pkg::StampW-1:0]         best_stamp_reg, best_stamp_next;
    logic                               page_match;
    logic                               better;

    assign page_match = ent_valid && (ent_page == ref_page);
    // smaller count wins, then older stamp; equal keeps the lower index
    assign better = !have_best_reg ||
                    ({ent_count, ent_stamp} < {best_count_reg, best_stamp_reg});

    always_comb begin
        res_next        = res_reg;
        have_best_next  = have_best_reg;
        best_count_next = best_count_reg;
        best_stamp_next = best_stamp_reg;
        if (start) begin
            res_next.hit   = 1'b0;
            res_next.empty = 1'b0;
            have_best_next = 1'b0;
        end else if (ent_strobe) begin
            if (page_match && !res_reg.hit) begin
                res_next.hit       = 1'b1;
                res_next.hit_idx   = ent_idx;
                res_next.hit_count = ent_count;
            end
            if (!ent_valid && !res_reg.empty) begin
                res_next.empty     = 1'b1;
                res_next.empty_idx = ent_idx;
            end
            if (ent_valid && better) begin
                have_best_next     = 1'b1;
                best_count_next    = ent_count;
                best_stamp_next    = ent_stamp;
                res_next.vict_idx  = ent_idx;
                res_next.vict_page = ent_page;
            end
        end
    end

    always_ff @(posedge aclk) begin
        res_reg        <= res_next;
        best_count_reg <= best_count_next;
        best_stamp_reg <= best_stamp_next;
    end

    // have-best flag only; the hit and empty flags sit in res_reg above
    always_ff @(posedge aclk) begin
        have_best_reg <= have_best_next;
    end

    assign res = res_reg;

endmodule

FILE: src/lfu_page_replacement_unit.sv
// top level: lfu frame table with lru tie-break, apb config, scan sequencer
`timescale 1ns / 1ps

// Usage
// One page reference enters on the s_ channel (s_valid/s_ready, s_page_number)
// and one result leaves on the m_ channel (m_valid/m_ready) per reference:
// hit flag, slot used, evicted page if any, and saturating hit and miss totals.
// The slot table (page, use count, stamp) sits in a memory with a
// registered read; valid bits are flip-flops. Each reference reads the active
// slots one per cycle through the single memory read port. One reference is
// processed at a time; s_ready is high only while idle, so a new reference is
// accepted only after the previous one has finished its update.
// The result sits in an output register; if m_ready is low, the next reference
// may still be accepted and scanned, and waits before its update until the
// previous result has been taken.
// Reset (aresetn low, synchronous) clears all valid bits, the reference clock,
// both totals, and sets frames_in_use to 16; no clearing pass is needed.
// The user writes frames_in_use (apb address 0) only while the block is idle; the block itself does not enforce this.

module lfu_page_replacement_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lfu_pkg::CfgAddrW-1:0]  paddr,
    input  logic [lfu_pkg::CfgDataW-1:0]  pwdata,
    output logic [lfu_pkg::CfgDataW-1:0]  prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [lfu_pkg::PageW-1:0]     s_page_number,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_was_hit,
    output logic [3:0]                    m_slot_used,
    output logic                          m_evicted_valid,
    output logic [lfu_pkg::PageW-1:0]     m_evicted_page,
    output logic [lfu_pkg::TotalW-1:0]    m_hit_total,
    output logic [lfu_pkg::TotalW-1:0]    m_miss_total
);

    localparam int IdxW = lfu_pkg::SlotIdxW;

    lfu_pkg::state_t                 state_reg, state_next;
    logic [lfu_pkg::FramesW-1:0]     frames_reg, frames_next;
    logic [lfu_pkg::FrameSlots-1:0]  valid_reg, valid_next;
    logic [lfu_pkg::TotalW-1:0]      clock_reg, clock_next;
    logic [lfu_pkg::TotalW-1:0]      hits_reg, hits_next;
    logic [lfu_pkg::TotalW-1:0]      misses_reg, misses_next;
    logic [lfu_pkg::PageW-1:0]       page_reg;
    logic [IdxW-1:0]                 last_idx_reg;
    logic [IdxW-1:0]                 last_idx;
    logic [IdxW-1:0]                 idx_reg, idx_next;
    logic                            rd_valid_reg;
    logic [IdxW-1:0]                 rd_idx_reg;

    logic                            m_valid_reg, m_valid_next;
    logic                            m_was_hit_reg;
    logic [3:0]                      m_slot_used_reg;
    logic                            m_evicted_valid_reg;
    logic [lfu_pkg::PageW-1:0]       m_evicted_page_reg;
    logic [lfu_pkg::TotalW-1:0]      m_hit_total_reg;
    logic [lfu_pkg::TotalW-1:0]      m_miss_total_reg;

    logic                            in_accept;
    logic                            cfg_write;
    logic                            do_update;
    logic                            out_free;

    logic                            ram_re;
    logic                            ram_we;
    logic [IdxW-1:0]                 wr_idx;
    logic [lfu_pkg::CountW-1:0]      wr_count;
    logic [lfu_pkg::EntryW-1:0]      ram_wdata;
    logic [lfu_pkg::EntryW-1:0]      ram_rdata;
    lfu_pkg::scan_res_t              scan_res;

    // apb register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == lfu_pkg::CfgIdxFrames);
    assign prdata    = (paddr[2] == lfu_pkg::CfgIdxFrames) ?
                       lfu_pkg::CfgDataW'(frames_reg) : '0;
    assign frames_next = cfg_write ? pwdata[lfu_pkg::FramesW-1:0] : frames_reg;

    // last active slot: zero acts as one, above the table size acts as full
    always_comb begin
        if (frames_reg == '0) begin
            last_idx = '0;
        end else if (frames_reg > lfu_pkg::FramesW'(lfu_pkg::FrameSlots)) begin
            last_idx = IdxW'(lfu_pkg::FrameSlots - 1);
        end else begin
            last_idx = IdxW'(frames_reg - lfu_pkg::FramesW'(1));
        end
    end

    assign in_accept = s_valid && s_ready;
    assign s_ready   = (state_reg == lfu_pkg::ST_IDLE);
    assign out_free  = !m_valid_reg || m_ready;
    assign do_update = (state_reg == lfu_pkg::ST_UPDATE) && out_free;
    assign ram_re    = (state_reg == lfu_pkg::ST_SCAN);

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            lfu_pkg::ST_IDLE: begin
                idx_next = '0;
                if (in_accept) begin
                    state_next = lfu_pkg::ST_SCAN;
                end
            end
            lfu_pkg::ST_SCAN: begin
                idx_next = idx_reg + IdxW'(1);
                if (idx_reg == last_idx_reg) begin
                    state_next = lfu_pkg::ST_DRAIN;
                end
            end
            lfu_pkg::ST_DRAIN: begin
                state_next = lfu_pkg::ST_UPDATE;
            end
            lfu_pkg::ST_UPDATE: begin
                if (out_free) begin
                    state_next = lfu_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lfu_pkg::ST_IDLE;
            end
        endcase
    end

    // write-back decision: hit slot, else first empty, else victim
    always_comb begin
        if (scan_res.hit) begin
            wr_idx   = scan_res.hit_idx;
            wr_count = (scan_res.hit_count == lfu_pkg::CountMax) ?
                       scan_res.hit_count : scan_res.hit_count + lfu_pkg::CountW'(1);
        end else if (scan_res.empty) begin
            wr_idx   = scan_res.empty_idx;
            wr_count = lfu_pkg::CountOne;
        end else begin
            wr_idx   = scan_res.vict_idx;
            wr_count = lfu_pkg::CountOne;
        end
    end

    assign ram_we    = do_update;
    assign ram_wdata = {page_reg, wr_count, clock_reg};

    always_comb begin
        valid_next  = valid_reg;
        hits_next   = hits_reg;
        misses_next = misses_reg;
        clock_next  = clock_reg;
        if (in_accept) begin
            clock_next = lfu_pkg::sat_inc32(clock_reg);
        end
        if (do_update) begin
            valid_next[wr_idx] = 1'b1;
            if (scan_res.hit) begin
                hits_next = lfu_pkg::sat_inc32(hits_reg);
            end else begin
                misses_next = lfu_pkg::sat_inc32(misses_reg);
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (do_update) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= lfu_pkg::ST_IDLE;
            frames_reg   <= lfu_pkg::FramesReset;
            valid_reg    <= '0;
            clock_reg    <= '0;
            hits_reg     <= '0;
            misses_reg   <= '0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            frames_reg   <= frames_next;
            valid_reg    <= valid_next;
            clock_reg    <= clock_next;
            hits_reg     <= hits_next;
            misses_reg   <= misses_next;
            rd_valid_reg <= ram_re;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        rd_idx_reg <= idx_reg;
        if (in_accept) begin
            page_reg     <= s_page_number;
            last_idx_reg <= last_idx;
        end
        if (do_update) begin
            m_was_hit_reg       <= scan_res.hit;
            m_slot_used_reg     <= 4'(wr_idx);
            m_evicted_valid_reg <= !scan_res.hit && !scan_res.empty;
            m_evicted_page_reg  <= (!scan_res.hit && !scan_res.empty) ?
                                   scan_res.vict_page : '0;
            m_hit_total_reg     <= hits_next;
            m_miss_total_reg    <= misses_next;
        end
    end

    lfu_slot_ram #(
        .Depth (lfu_pkg::FrameSlots),
        .Width (lfu_pkg::EntryW)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wr_idx),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    lfu_victim_scan u_victim_scan (
        .aclk       (aclk),
        .start      (in_accept),
        .ref_page   (page_reg),
        .ent_strobe (rd_valid_reg),
        .ent_idx    (rd_idx_reg),
        .ent_valid  (valid_reg[rd_idx_reg]),
        .ent_page   (ram_rdata[lfu_pkg::EntryW-1 -: lfu_pkg::PageW]),
        .ent_count  (ram_rdata[lfu_pkg::StampW +: lfu_pkg::CountW]),
        .ent_stamp  (ram_rdata[lfu_pkg::StampW-1:0]),
        .res        (scan_res)
    );

    assign m_valid         = m_valid_reg;
    assign m_was_hit       = m_was_hit_reg;
    assign m_slot_used     = m_slot_used_reg;
    assign m_evicted_valid = m_evicted_valid_reg;
    assign m_evicted_page  = m_evicted_page_reg;
    assign m_hit_total     = m_hit_total_reg;
    assign m_miss_total    = m_miss_total_reg;

endmodule

FILE: bench/testbench.sv
// testbench for the lfu page replacement unit: directed and random page references
`timescale 1ns / 1ps

module testbench;

    typedef struct packed {
        logic                       was_hit;
        logic [3:0]                 slot_used;
        logic                       evicted_valid;
        logic [lfu_pkg::PageW-1:0]  evicted_page;
        logic [lfu_pkg::TotalW-1:0] hit_total;
        logic [lfu_pkg::TotalW-1:0] miss_total;
    } page_outcome_t;

    localparam logic [lfu_pkg::CfgAddrW-1:0] FramesAddr = {lfu_pkg::CfgIdxFrames, 2'b00};
    localparam int TimeoutNs = 2_000_000;

    logic                         aclk;
    logic                         aresetn;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [lfu_pkg::CfgAddrW-1:0] paddr;
    logic [lfu_pkg::CfgDataW-1:0] pwdata;
    logic [lfu_pkg::CfgDataW-1:0] prdata;
    logic                         pready;
    logic                         s_valid;
    logic                         s_ready;
    logic [lfu_pkg::PageW-1:0]    s_page_number;
    logic                         m_valid;
    logic                         m_ready;
    logic                         m_was_hit;
    logic [3:0]                   m_slot_used;
    logic                         m_evicted_valid;
    logic [lfu_pkg::PageW-1:0]    m_evicted_page;
    logic [lfu_pkg::TotalW-1:0]   m_hit_total;
    logic [lfu_pkg::TotalW-1:0]   m_miss_total;

    // shadow copy of the frame table
    logic [lfu_pkg::PageW-1:0]   shadow_page  [lfu_pkg::FrameSlots];
    logic                        shadow_valid [lfu_pkg::FrameSlots];
    logic [lfu_pkg::CountW-1:0]  shadow_count [lfu_pkg::FrameSlots];
    logic [lfu_pkg::StampW-1:0]  shadow_stamp [lfu_pkg::FrameSlots];
    logic [lfu_pkg::StampW-1:0]  shadow_clock;
    logic [lfu_pkg::TotalW-1:0]  shadow_hits;
    logic [lfu_pkg::TotalW-1:0]  shadow_misses;
    logic [lfu_pkg::FramesW-1:0] shadow_frames;

    page_outcome_t pending_outcomes[$];
    int            errors;
    bit            steady_flow;

    lfu_page_replacement_unit uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_page_number   (s_page_number),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_was_hit       (m_was_hit),
        .m_slot_used     (m_slot_used),
        .m_evicted_valid (m_evicted_valid),
        .m_evicted_page  (m_evicted_page),
        .m_hit_total     (m_hit_total),
        .m_miss_total    (m_miss_total)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #(TimeoutNs);
        $display("lfu_page_replacement_unit regression: fail");
        $finish;
    end

    function automatic int pick_gap();
        int roll;
        if (steady_flow) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 40) return 0;
        if (roll < 90) return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    // applies one reference to the shadow table and returns what the block should report
    function automatic page_outcome_t reference_page(input logic [lfu_pkg::PageW-1:0] page);
        page_outcome_t res;
        int active;
        int slot;
        int i;
        bit hit;
        bit empty;
        res = '0;
        active = int'(shadow_frames);
        if (active < 1) active = 1;
        if (active > lfu_pkg::FrameSlots) active = lfu_pkg::FrameSlots;
        if (shadow_clock != '1) shadow_clock = shadow_clock + lfu_pkg::StampW'(1);
        slot = 0;
        hit = 1'b0;
        for (i = 0; i < active; i++) begin
            if (!hit && shadow_valid[i] && shadow_page[i] == page) begin
                hit = 1'b1;
                slot = i;
            end
        end
        if (hit) begin
            if (shadow_count[slot] != '1)
                shadow_count[slot] = shadow_count[slot] + lfu_pkg::CountW'(1);
            shadow_stamp[slot] = shadow_clock;
            if (shadow_hits != '1) shadow_hits = shadow_hits + lfu_pkg::TotalW'(1);
        end else begin
            if (shadow_misses != '1) shadow_misses = shadow_misses + lfu_pkg::TotalW'(1);
            empty = 1'b0;
            for (i = 0; i < active; i++) begin
                if (!empty && !shadow_valid[i]) begin
                    empty = 1'b1;
                    slot = i;
                end
            end
            if (!empty) begin
                // least count loses, then oldest stamp, then lowest index
                slot = 0;
                for (i = 1; i < active; i++) begin
                    if (shadow_count[i] < shadow_count[slot] ||
                        (shadow_count[i] == shadow_count[slot] &&
                         shadow_stamp[i] < shadow_stamp[slot]))
                        slot = i;
                end
                res.evicted_valid = 1'b1;
                res.evicted_page = shadow_page[slot];
            end
            shadow_page[slot] = page;
            shadow_valid[slot] = 1'b1;
            shadow_count[slot] = lfu_pkg::CountW'(1);
            shadow_stamp[slot] = shadow_clock;
        end
        res.was_hit = hit;
        res.slot_used = 4'(slot);
        res.hit_total = shadow_hits;
        res.miss_total = shadow_misses;
        return res;
    endfunction

    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        end
    endtask

    // result checker
    always @(posedge aclk) begin
        page_outcome_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_outcomes.size() == 0) begin
                errors++;
                $display("%0t: result transaction with nothing expected", $time);
            end else begin
                want = pending_outcomes.pop_front();
                check_field("was_hit", 64'(want.was_hit), 64'(m_was_hit));
                check_field("slot_used", 64'(want.slot_used), 64'(m_slot_used));
                check_field("evicted_valid", 64'(want.evicted_valid),
                            64'(m_evicted_valid));
                check_field("evicted_page", 64'(want.evicted_page), 64'(m_evicted_page));
                check_field("hit_total", 64'(want.hit_total), 64'(m_hit_total));
                check_field("miss_total", 64'(want.miss_total), 64'(m_miss_total));
            end
        end
    end

    // result side backpressure
    initial begin
        int hold;
        hold = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold > 0) begin
                m_ready = 1'b0;
                hold--;
            end else begin
                m_ready = 1'b1;
                if ($urandom_range(0, 2) == 0) hold = pick_gap();
            end
        end
    end

    // called right after a falling edge, returns right after one
    task automatic send_page(input logic [lfu_pkg::PageW-1:0] page);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_page_number = page;
        do @(posedge aclk); while (!s_ready);
        pending_outcomes.push_back(reference_page(page));
        @(negedge aclk);
    endtask

    task automatic wait_for_results();
        s_valid = 1'b0;
        while (pending_outcomes.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_frames(input logic [lfu_pkg::CfgDataW-1:0] value);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = FramesAddr;
        pwdata = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        shadow_frames = value[lfu_pkg::FramesW-1:0];
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic read_frames();
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = FramesAddr;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        check_field("frames_in_use readback", 64'(shadow_frames), 64'(prdata));
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    // default of 16 slots, page extremes, first hits
    task automatic test_reset_state();
        read_frames();
        send_page(16'h0000);
        send_page(16'hFFFF);
        send_page(16'h0000);
        send_page(16'hFFFF);
        send_page(16'hAAAA);
        send_page(16'h5555);
        wait_for_results();
    endtask

    // two slots: both fill, then the page with the lower use count is evicted
    task automatic test_lfu_eviction();
        write_frames(32'd2);
        read_frames();
        send_page(16'h5A5A);
        send_page(16'h5A5A);
        send_page(16'h1234);
        send_page(16'h1234);
        send_page(16'h1234);
        send_page(16'h4321);
        wait_for_results();
    endtask

    // zero acts as one, oversize acts as all, parked slots keep contents,
    // and a page held twice hits at the lower slot
    task automatic test_frame_bounds();
        write_frames(32'd0);
        read_frames();
        send_page(16'h4321);
        send_page(16'h1111);
        wait_for_results();
        write_frames(32'hFFFF_FFFF);
        read_frames();
        send_page(16'h1234);
        send_page(16'hBEEF);
        wait_for_results();
        write_frames(32'h8000_0002);
        read_frames();
        send_page(16'hBEEF);
        wait_for_results();
        write_frames(32'd16);
        read_frames();
        send_page(16'hBEEF);
        wait_for_results();
    endtask

    // random references from a small working set plus stray pages
    task automatic test_random_references(input int setting, input int items,
                                          input bit steady, input bit pause_midway);
        logic [lfu_pkg::PageW-1:0] working_set[$];
        logic [lfu_pkg::PageW-1:0] page;
        int set_size;
        int k;
        write_frames(($urandom & 32'hFFFF_FFE0) | lfu_pkg::CfgDataW'(setting));
        read_frames();
        steady_flow = steady;
        set_size = $urandom_range(1, 24);
        repeat (set_size) working_set.push_back(lfu_pkg::PageW'($urandom));
        for (k = 0; k < items; k++) begin
            if (pause_midway && k == items / 2) wait_for_results();
            if ($urandom_range(0, 4) == 0)
                page = lfu_pkg::PageW'($urandom);
            else
                page = working_set[$urandom_range(0, working_set.size() - 1)];
            send_page(page);
        end
        wait_for_results();
        steady_flow = 1'b0;
    endtask

    initial begin
        int settings[9];
        int p;
        settings = '{1, 16, 4, 0, 31, 8, 3, 16, 12};
        errors = 0;
        steady_flow = 1'b0;
        aresetn = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_valid = 1'b0;
        s_page_number = '0;
        for (p = 0; p < lfu_pkg::FrameSlots; p++) begin
            shadow_page[p] = '0;
            shadow_valid[p] = 1'b0;
            shadow_count[p] = '0;
            shadow_stamp[p] = '0;
        end
        shadow_clock = '0;
        shadow_hits = '0;
        shadow_misses = '0;
        shadow_frames = lfu_pkg::FramesW'(16);
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_reset_state();
        test_lfu_eviction();
        test_frame_bounds();
        for (p = 0; p < 9; p++)
            test_random_references(settings[p], 50, (p == 2 || p == 6), (p == 1));

        wait_for_results();
        repeat (40) @(negedge aclk);
        if (errors == 0)
            $display("lfu_page_replacement_unit regression: pass");
        else
            $display("lfu_page_replacement_unit regression: fail");
        $finish;
    end

endmodule
